// ----- rtl/assert_macros.svh -----
// Assertion macros for the spectrogram column shader.
// Relies on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SPCS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a property holds in the cycle after a condition.
`define SPCS_CHECK_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/spcs_pkg.sv -----
// Shared types, constants and codes of the spectrogram column shader.
// No dependencies; every module of the block refers to it by scoped names.
package spcs_pkg;

  // Limits of the band and column counters
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_WIDTH  = 65536;
  localparam int BAND_W     = $clog2(MAX_HEIGHT);
  localparam int COL_W      = $clog2(MAX_WIDTH);

  // Field widths
  localparam int MAG_W    = 16;
  localparam int HEIGHT_W = 12;
  localparam int WIDTH_W  = 16;
  localparam int GRAY_W   = 8;
  localparam int DIFF_W   = MAG_W + 1;

  // Compare widths between counters and size registers
  localparam int BAND_CMP_W = (BAND_W > HEIGHT_W) ? BAND_W : HEIGHT_W;
  localparam int COL_CMP_W  = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;
  typedef logic [BAND_CMP_W-1:0] band_cmp_t;
  typedef logic [COL_CMP_W-1:0]  col_cmp_t;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd2;

  localparam logic [MAG_W-1:0]    THRESHOLD_RST = 16'h9C00;  // -100 dB
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST    = 12'd200;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST     = 16'd1024;

  // Shade arithmetic, unsigned Q2.16
  localparam int FRAC_W    = 16;
  localparam int SHADE_W   = 18;
  localparam int DIV_STEPS = SHADE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int REM_W     = MAG_W + SHADE_W;
  localparam logic [FRAC_W:0]    SHADE_ONE = 17'h10000;
  localparam logic [SHADE_W-1:0] SHADE_MAX = 18'h3FFFF;

  // Quadratic part of the curve: 85*s*s / (9 * 2^18)
  localparam int SQ_W     = 2 * FRAC_W;
  localparam int SCALED_W = SQ_W + 7;
  localparam logic [6:0] CURVE_GAIN = 7'd85;
  localparam int NINE_SHIFT = 18;
  localparam int Y9_W       = 19;
  // floor(y/9) = (y * RECIP_NINE) >> RECIP_SHIFT, exact for y below 2^21
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 19'd466034;
  localparam int PROD_W = Y9_W + RECIP_W;

  // Knee and linear part: 0.375*s + 0.625
  localparam int LIN_W = SHADE_W + 3;
  localparam logic [LIN_W-1:0] KNEE_LIMIT = 21'd196608;  // 5*s < 3.0
  localparam logic [LIN_W-1:0] LIN_OFFSET = 21'd327680;  // 5.0 before the divide by 8

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [MAG_W-1:0] magnitude_db;
    logic                    last_band;
  } spcs_in_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  pixel_x;
    logic [HEIGHT_W-1:0] pixel_y;
    logic [GRAY_W-1:0]   gray_level;
    logic                image_done;
  } spcs_out_t;

  // One pending job: a pixel to shade or the done marker
  typedef struct packed {
    logic                is_done;
    logic [WIDTH_W-1:0]  x;
    logic [HEIGHT_W-1:0] y;
    logic [MAG_W-1:0]    diff;
  } spcs_job_t;

  typedef struct packed {
    logic      push;
    spcs_job_t job;
  } spcs_qwr_t;

  typedef struct packed {
    logic done_signalled;
  } spcs_front_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_SQ    = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_RECIP = 6'b010000,
    ST_EMIT  = 6'b100000
  } spcs_state_t;

endpackage

// ----- rtl/spcs_front.sv -----
// Front end: accepts bands, tracks band/column position and the done flag.
// Depends on spcs_pkg; pushes pixel and done jobs into spcs_queue.
module spcs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  spcs_pkg::spcs_in_t                   in_data,
  input  logic [spcs_pkg::MAG_W-1:0]           threshold,
  input  logic [spcs_pkg::HEIGHT_W-1:0]        height,
  input  logic [spcs_pkg::WIDTH_W-1:0]         width,
  input  logic                                 q_full,
  output spcs_pkg::spcs_qwr_t                  q_wr,
  output spcs_pkg::spcs_front_stat_t           stat
);

  logic [spcs_pkg::BAND_W-1:0]  band_r, band_nxt;
  logic [spcs_pkg::COL_W-1:0]   col_r, col_nxt;
  logic                         done_sig_r, done_sig_nxt;
  logic                         accept;
  logic                         col_done;
  logic                         band_in;
  logic [spcs_pkg::DIFF_W-1:0]  diff;
  logic                         diff_pos;
  spcs_pkg::band_cmp_t          row_full;
  spcs_pkg::col_cmp_t           col_ext;

  // Take a transaction whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the band against the current position
  assign col_ext  = spcs_pkg::col_cmp_t'(col_r);
  assign col_done = col_ext >= spcs_pkg::col_cmp_t'(width);
  assign band_in  = spcs_pkg::band_cmp_t'(band_r) < spcs_pkg::band_cmp_t'(height);
  assign diff     = {in_data.magnitude_db[spcs_pkg::MAG_W-1], in_data.magnitude_db}
                  - {threshold[spcs_pkg::MAG_W-1], threshold};
  assign diff_pos = !diff[spcs_pkg::DIFF_W-1] && (diff[spcs_pkg::MAG_W-1:0] != '0);
  assign row_full = spcs_pkg::band_cmp_t'(height) - spcs_pkg::band_cmp_t'(1)
                  - spcs_pkg::band_cmp_t'(band_r);

  // Build the queue write
  always_comb begin
    q_wr.job.is_done = col_done;
    q_wr.job.x       = col_done ? '0 : col_ext[spcs_pkg::WIDTH_W-1:0];
    q_wr.job.y       = col_done ? '0 : row_full[spcs_pkg::HEIGHT_W-1:0];
    q_wr.job.diff    = diff[spcs_pkg::MAG_W-1:0];
    if (col_done) begin
      q_wr.push = accept && !done_sig_r;
    end else begin
      q_wr.push = accept && band_in && diff_pos;
    end
  end

  // Advance band and column counters, saturating at their limits, and latch the done flag
  always_comb begin
    band_nxt     = band_r;
    col_nxt      = col_r;
    done_sig_nxt = done_sig_r;
    if (accept) begin
      if (col_done) begin
        done_sig_nxt = 1'b1;
      end
      if (in_data.last_band) begin
        band_nxt = '0;
        if (col_r != spcs_pkg::COL_W'(spcs_pkg::MAX_WIDTH - 1)) begin
          col_nxt = col_r + 1'b1;
        end
      end else if (band_r != spcs_pkg::BAND_W'(spcs_pkg::MAX_HEIGHT - 1)) begin
        band_nxt = band_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r     <= '0;
      col_r      <= '0;
      done_sig_r <= 1'b0;
    end else begin
      band_r     <= band_nxt;
      col_r      <= col_nxt;
      done_sig_r <= done_sig_nxt;
    end
  end

  assign stat.done_signalled = done_sig_r;

endmodule

// ----- rtl/spcs_queue.sv -----
// Short job queue between the front end and the shading back end.
// Depends on spcs_pkg for the job type and depth.
module spcs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spcs_pkg::spcs_qwr_t  q_wr,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output spcs_pkg::spcs_job_t  head
);

  spcs_pkg::spcs_job_t              entry_r [spcs_pkg::QUEUE_DEPTH];
  logic [spcs_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [spcs_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [spcs_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full    = count_r == spcs_pkg::QCNT_W'(spcs_pkg::QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = q_wr.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == spcs_pkg::QPTR_W'(spcs_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == spcs_pkg::QPTR_W'(spcs_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the job payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_wr.job;
    end
  end

endmodule

// ----- rtl/spcs_back.sv -----
// Back end: divides the level difference into a shade, applies the curve
// and holds the result in the output register. Depends on spcs_pkg.
module spcs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  spcs_pkg::spcs_job_t           q_head,
  output logic                          q_pop,
  input  logic [spcs_pkg::MAG_W-1:0]    den,
  output logic                          out_valid,
  input  logic                          out_stall,
  output spcs_pkg::spcs_out_t           out_data
);

  spcs_pkg::spcs_state_t                 state_r, state_nxt;
  spcs_pkg::spcs_job_t                   job_r, job_nxt;
  logic [spcs_pkg::SHADE_W-1:0]          s_r, s_nxt;
  logic [spcs_pkg::REM_W-1:0]            rem_r, rem_nxt;
  logic [spcs_pkg::REM_W-1:0]            dv_r, dv_nxt;
  logic [spcs_pkg::STEP_W-1:0]           step_r, step_nxt;
  logic [spcs_pkg::SQ_W-1:0]             sq_r, sq_nxt;
  logic [spcs_pkg::Y9_W-1:0]             y9_r, y9_nxt;
  logic [spcs_pkg::FRAC_W-1:0]           c_low_r, c_low_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  spcs_pkg::spcs_out_t                   out_data_r, out_data_nxt;

  logic                                  sat;
  logic                                  ge;
  logic [spcs_pkg::SCALED_W-1:0]         scaled;
  logic [spcs_pkg::PROD_W-1:0]           prod;
  logic [spcs_pkg::LIN_W-1:0]            s_ext;
  logic [spcs_pkg::LIN_W-1:0]            lin_sum;
  logic                                  is_low;
  logic [spcs_pkg::SHADE_W-1:0]          curve;
  logic [spcs_pkg::FRAC_W:0]             clamped;
  logic [spcs_pkg::FRAC_W:0]             inv;
  logic [spcs_pkg::FRAC_W+spcs_pkg::GRAY_W:0] gray_prod;
  logic                                  out_free;

  // Quotient would pass the saturation limit (also covers a zero divisor)
  assign sat = {2'b00, q_head.diff} >= {den, 2'b00};
  // One restoring step of the divider
  assign ge  = rem_r >= dv_r;

  // Curve arithmetic
  assign scaled  = spcs_pkg::SCALED_W'(sq_r) * spcs_pkg::SCALED_W'(spcs_pkg::CURVE_GAIN);
  assign prod    = spcs_pkg::PROD_W'(y9_r) * spcs_pkg::PROD_W'(spcs_pkg::RECIP_NINE);
  assign s_ext   = spcs_pkg::LIN_W'(s_r);
  assign lin_sum = (s_ext << 1) + s_ext + spcs_pkg::LIN_OFFSET;
  assign is_low  = ((s_ext << 2) + s_ext) < spcs_pkg::KNEE_LIMIT;
  assign curve   = is_low ? spcs_pkg::SHADE_W'(c_low_r) : lin_sum[spcs_pkg::LIN_W-1:3];
  assign clamped = (curve > spcs_pkg::SHADE_W'(spcs_pkg::SHADE_ONE)) ? spcs_pkg::SHADE_ONE
                 : curve[spcs_pkg::FRAC_W:0];
  assign inv     = spcs_pkg::SHADE_ONE - clamped;
  // inv * 255
  assign gray_prod = {inv, {spcs_pkg::GRAY_W{1'b0}}}
                   - {{spcs_pkg::GRAY_W{1'b0}}, inv};

  assign out_free = !out_valid_r || !out_stall;

  // Sequence one job at a time
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    step_nxt      = step_r;
    sq_nxt        = sq_r;
    y9_nxt        = y9_r;
    c_low_nxt     = c_low_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    case (state_r)
      spcs_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          job_nxt  = q_head;
          rem_nxt  = {{(spcs_pkg::REM_W - spcs_pkg::MAG_W - spcs_pkg::FRAC_W){1'b0}},
                      q_head.diff, {spcs_pkg::FRAC_W{1'b0}}};
          dv_nxt   = {1'b0, den, {(spcs_pkg::SHADE_W - 1){1'b0}}};
          s_nxt    = sat ? spcs_pkg::SHADE_MAX : '0;
          step_nxt = spcs_pkg::STEP_W'(spcs_pkg::DIV_STEPS - 1);
          if (q_head.is_done) begin
            state_nxt = spcs_pkg::ST_EMIT;
          end else if (sat) begin
            state_nxt = spcs_pkg::ST_SQ;
          end else begin
            state_nxt = spcs_pkg::ST_DIV;
          end
        end
      end
      spcs_pkg::ST_DIV: begin
        rem_nxt = ge ? rem_r - dv_r : rem_r;
        s_nxt   = {s_r[spcs_pkg::SHADE_W-2:0], ge};
        dv_nxt  = dv_r >> 1;
        if (step_r == '0) begin
          state_nxt = spcs_pkg::ST_SQ;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      spcs_pkg::ST_SQ: begin
        sq_nxt    = s_r[spcs_pkg::FRAC_W-1:0] * s_r[spcs_pkg::FRAC_W-1:0];
        state_nxt = spcs_pkg::ST_SCALE;
      end
      spcs_pkg::ST_SCALE: begin
        y9_nxt    = scaled[spcs_pkg::NINE_SHIFT +: spcs_pkg::Y9_W];
        state_nxt = spcs_pkg::ST_RECIP;
      end
      spcs_pkg::ST_RECIP: begin
        c_low_nxt = prod[spcs_pkg::RECIP_SHIFT +: spcs_pkg::FRAC_W];
        state_nxt = spcs_pkg::ST_EMIT;
      end
      spcs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (job_r.is_done) begin
            out_data_nxt.pixel_x    = '0;
            out_data_nxt.pixel_y    = '0;
            out_data_nxt.gray_level = '0;
            out_data_nxt.image_done = 1'b1;
          end else begin
            out_data_nxt.pixel_x    = job_r.x;
            out_data_nxt.pixel_y    = job_r.y;
            out_data_nxt.gray_level = gray_prod[spcs_pkg::FRAC_W +: spcs_pkg::GRAY_W];
            out_data_nxt.image_done = 1'b0;
          end
          state_nxt = spcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spcs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    s_r        <= s_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    step_r     <= step_nxt;
    sq_r       <= sq_nxt;
    y9_r       <= y9_nxt;
    c_low_r    <= c_low_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/spectrogram_column_shader.sv -----
// Spectrogram column shader: turns a stream of dB band magnitudes into gray
// pixel writes, one image column per frame. The front end takes one band per
// cycle while its two-entry queue has room; bands that give no pixel (at or
// below the noise floor, above the image height, or after the done result)
// never reach the back end. A band with a pixel passes the 18-step restoring
// divider that forms the shade, then four curve steps; a saturating shade
// skips the divider, and the done result goes straight to emit. Results leave
// through an output register, so the back end starts the next job while a
// result waits. The user must see that configuration is written through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
// Depends on spcs_pkg, spcs_front, spcs_queue, spcs_back and assert_macros.svh.
`include "assert_macros.svh"

module spectrogram_column_shader (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  spcs_pkg::spcs_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output spcs_pkg::spcs_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [spcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [spcs_pkg::MAG_W-1:0]     threshold_r, threshold_nxt;
  logic [spcs_pkg::HEIGHT_W-1:0]  height_r, height_nxt;
  logic [spcs_pkg::WIDTH_W-1:0]   width_r, width_nxt;
  logic [spcs_pkg::MAG_W-1:0]     den;
  spcs_pkg::spcs_qwr_t            q_wr;
  spcs_pkg::spcs_job_t            q_head;
  spcs_pkg::spcs_front_stat_t     front_stat;
  logic                           q_full;
  logic                           q_empty;
  logic                           q_pop;

  // Decode configuration writes; unknown indexes are dropped
  always_comb begin
    threshold_nxt = threshold_r;
    height_nxt    = height_r;
    width_nxt     = width_r;
    if (cfg_we) begin
      case (cfg_index)
        spcs_pkg::CFG_THRESHOLD: threshold_nxt = cfg_wdata[spcs_pkg::MAG_W-1:0];
        spcs_pkg::CFG_HEIGHT:    height_nxt    = cfg_wdata[spcs_pkg::HEIGHT_W-1:0];
        spcs_pkg::CFG_WIDTH:     width_nxt     = cfg_wdata[spcs_pkg::WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= spcs_pkg::THRESHOLD_RST;
      height_r    <= spcs_pkg::HEIGHT_RST;
      width_r     <= spcs_pkg::WIDTH_RST;
    end else begin
      threshold_r <= threshold_nxt;
      height_r    <= height_nxt;
      width_r     <= width_nxt;
    end
  end

  // Magnitude of the noise floor, the shade divisor
  assign den = threshold_r[spcs_pkg::MAG_W-1] ? (~threshold_r + 1'b1) : threshold_r;

  spcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .threshold (threshold_r),
    .height    (height_r),
    .width     (width_r),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .stat      (front_stat)
  );

  spcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  spcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .den       (den),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue is never written full or read empty
  `SPCS_CHECK(a_push_not_full, !(q_wr.push && q_full), "job pushed into full queue")
  `SPCS_CHECK(a_pop_not_empty, !(q_pop && q_empty), "job popped from empty queue")
  // A done job is queued only once and latches the done flag
  `SPCS_CHECK_NEXT(a_done_once, q_wr.push && q_wr.job.is_done && !q_full, front_stat.done_signalled, "done job did not set the done flag")
  `SPCS_CHECK(a_done_first, !(q_wr.push && q_wr.job.is_done && front_stat.done_signalled), "second done job queued")

endmodule
